// ----- hdl/imh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_pkg: shared constants for the indexed min-heap
// Default sizes used by the top level and the testbench.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
package imh_pkg;
  localparam int CAPACITY_DEF   = 256;
  localparam int NODE_COUNT_DEF = 256;
  localparam int KEY_WIDTH_DEF  = 32;
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;
endpackage

// ----- hdl/imh_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read of the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- hdl/indexed_min_heap_decrease_key_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_top: indexed binary min-heap with decrease-key
// Heap slots and the node-to-slot table live in single-port RAMs; one
// sequencer walks sift-up and sift-down a level at a time.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit up)                        tuser
// s_axis   in   distance[31:0], node[39:32]               op
// m_axis   out  top_distance[31:0], top_node[39:32],      dropped
//               heap_empty[40], entry_count[49:41]
// One shared key comparator and the single RAM port of the slot store set the
// pace: each sift-up level reads the parent, compares and swaps; each
// sift-down level reads both children, compares and swaps. A new item is
// taken only once the last has finished.
// After reset the position table is cleared, one entry a cycle; s_axis_tready
// rises once all NODE_COUNT entries are clear. The result is registered: a
// new item is taken while it waits, but cannot finish until it is transferred.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key_top #(
  parameter int CAPACITY   = imh_pkg::CAPACITY_DEF,
  parameter int NODE_COUNT = imh_pkg::NODE_COUNT_DEF,
  parameter int KEY_WIDTH  = imh_pkg::KEY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // distance[31:0], node[39:32]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // top_distance, top_node, heap_empty,
                                      // entry_count, zero fill
  output logic        m_axis_tuser    // dropped
);
  localparam int SW = $clog2(CAPACITY);
  localparam int NW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_WIDTH + NW;         // slot entry: key, node
  localparam int PW = SW + 1;                 // position entry: present, slot

  typedef enum logic [18:0] {
    S_CLEAR = 19'h00001, S_IDLE  = 19'h00002, S_PCHK  = 19'h00004,
    S_NEW   = 19'h00008, S_DRD   = 19'h00010, S_DCHK  = 19'h00020,
    S_DWR   = 19'h00040, S_URD   = 19'h00080, S_UCMP  = 19'h00100,
    S_USW   = 19'h00200, S_PCLR  = 19'h00400, S_LGET  = 19'h00800,
    S_DN    = 19'h01000, S_DR    = 19'h02000, S_DCMP  = 19'h04000,
    S_DSW   = 19'h08000, S_FIN   = 19'h10000, S_FGET  = 19'h20000,
    S_SPARE = 19'h40000
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [SW-1:0] cur, oth;          // current slot and chosen child slot
  logic [EW-1:0] cur_e, lft_e;
  logic          l_lt;
  logic [KEY_WIDTH-1:0] in_key;
  logic [NW-1:0]        in_node;
  logic          node_ok, drop;
  logic [NW:0]   clr;

  // RAM ports.
  logic          h_we, p_we;
  logic [SW-1:0] h_addr;
  logic [EW-1:0] h_wd, h_rd;
  logic [NW-1:0] p_addr;
  logic [PW-1:0] p_wd, p_rd;

  imh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd));
  imh_ram #(.WIDTH(PW), .DEPTH(NODE_COUNT)) u_pos (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd));

  function automatic logic [KEY_WIDTH-1:0] key_of(input logic [EW-1:0] e);
    return e[EW-1:NW];
  endfunction
  function automatic logic [NW-1:0] node_of(input logic [EW-1:0] e);
    return e[NW-1:0];
  endfunction

  // Truncated input key and node; wider keys zero extend.
  logic [63:0] dist_ext;
  logic [16:0] node_ext;
  assign dist_ext = {32'd0, s_axis_tdata[31:0]};
  assign node_ext = {9'd0, s_axis_tdata[39:32]};

  // Slot arithmetic: parent, children, last entry.
  logic [SW-1:0] par;
  logic [CW-1:0] last;
  logic [SW+1:0] lslot, rslot, count_w;
  logic          l_ok, r_ok;
  assign par     = (cur - SW'(1)) >> 1;
  assign last    = count - CW'(1);
  assign lslot   = {1'b0, cur, 1'b1};
  assign rslot   = lslot + (SW+2)'(1);
  assign count_w = (SW+2)'(count);
  assign l_ok    = lslot < count_w;
  assign r_ok    = rslot < count_w;

  // Shared key comparator: key_lt is cmp_a < cmp_b.
  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic [EW-1:0]        base_e;
  logic                 key_lt, r_lt;
  assign base_e = l_lt ? lft_e : cur_e;
  always_comb begin
    cmp_a = key_of(h_rd);
    cmp_b = key_of(cur_e);
    case (state)
      S_UCMP: begin
        cmp_a = key_of(cur_e); cmp_b = key_of(h_rd);
      end
      S_DCHK: begin
        cmp_a = in_key; cmp_b = key_of(h_rd);
      end
      S_DCMP:  cmp_b = key_of(base_e);
      default: ;
    endcase
  end
  assign key_lt = cmp_a < cmp_b;
  assign r_lt   = r_ok && key_lt;

  // Result load: the root is on the read port and the output register is free.
  logic        out_load;
  logic        empty;
  logic [63:0] root_key_ext;
  logic [15:0] root_node_ext;
  logic [16:0] count_ext;
  assign out_load      = (state == S_FGET) && (!m_axis_tvalid || m_axis_tready);
  assign empty         = (count == '0);
  assign root_key_ext  = 64'(key_of(h_rd));
  assign root_node_ext = 16'(node_of(h_rd));
  assign count_ext     = 17'(count);

  assign s_axis_tready = (state == S_IDLE);

  // RAM port steering by state.
  always_comb begin
    h_we = 1'b0; h_addr = '0; h_wd = cur_e;
    p_we = 1'b0; p_addr = node_of(cur_e); p_wd = {1'b1, cur};
    unique case (state)
      S_CLEAR: begin
        p_we = 1'b1; p_addr = clr[NW-1:0]; p_wd = '0;
      end
      S_IDLE:  p_addr = NW'(node_ext);
      S_PCHK:  ;
      S_NEW: begin
        h_we = 1'b1; h_addr = cur; h_wd = cur_e;
        p_we = 1'b1; p_addr = node_of(cur_e); p_wd = {1'b1, cur};
      end
      S_DRD:   h_addr = cur;
      S_DCHK:  ;
      S_DWR: begin
        h_we = 1'b1; h_addr = cur; h_wd = cur_e;
      end
      S_URD:   h_addr = par;
      S_UCMP: begin
        // Parent strictly larger: it moves down into the current slot.
        if (key_lt) begin
          h_we = 1'b1; h_addr = cur; h_wd = h_rd;
          p_we = 1'b1; p_addr = node_of(h_rd); p_wd = {1'b1, cur};
        end
      end
      S_USW: begin
        h_we = 1'b1; h_addr = par; h_wd = cur_e;
        p_we = 1'b1; p_addr = node_of(cur_e); p_wd = {1'b1, par};
      end
      S_PCLR: begin
        h_addr = last[SW-1:0];
        p_we = 1'b1; p_addr = node_of(h_rd); p_wd = '0;
      end
      S_LGET: begin
        h_we = 1'b1; h_addr = '0; h_wd = h_rd;
        p_we = 1'b1; p_addr = node_of(h_rd); p_wd = {1'b1, {SW{1'b0}}};
      end
      S_DN:    h_addr = lslot[SW-1:0];
      S_DR:    h_addr = rslot[SW-1:0];
      S_DCMP: begin
        // The smaller child moves up; the left child wins a tie.
        if (r_lt) begin
          h_we = 1'b1; h_addr = cur; h_wd = h_rd;
          p_we = 1'b1; p_addr = node_of(h_rd); p_wd = {1'b1, cur};
        end else if (l_lt) begin
          h_we = 1'b1; h_addr = cur; h_wd = lft_e;
          p_we = 1'b1; p_addr = node_of(lft_e); p_wd = {1'b1, cur};
        end
      end
      S_DSW: begin
        h_we = 1'b1; h_addr = oth; h_wd = cur_e;
        p_we = 1'b1; p_addr = node_of(cur_e); p_wd = {1'b1, oth};
      end
      S_FIN:   h_addr = '0;
      S_FGET:  h_addr = '0;
      default: ;
    endcase
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; count <= '0; clr <= '0; m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0; m_axis_tuser <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + (NW+1)'(1);
          if (clr == (NW+1)'(NODE_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid) begin
          in_key  <= KEY_WIDTH'(dist_ext);
          in_node <= NW'(node_ext);
          node_ok <= node_ext < 17'(NODE_COUNT);
          drop    <= 1'b0;
          if (s_axis_tuser == imh_pkg::OP_PUSH) begin
            state <= S_PCHK;
          end else if (count != '0) begin
            // Pop: the root is being read.
            state <= S_PCLR;
          end else begin
            state <= S_FIN;
          end
        end
        S_PCHK: begin
          if (!node_ok) begin
            state <= S_FIN;
          end else if (p_rd[PW-1]) begin
            // Present: fetch its entry and check for a strictly smaller key.
            cur <= p_rd[SW-1:0]; state <= S_DRD;
          end else if (count == CW'(CAPACITY)) begin
            drop <= 1'b1; state <= S_FIN;
          end else begin
            cur   <= count[SW-1:0];
            cur_e <= {in_key, in_node};
            count <= count + CW'(1);
            state <= S_NEW;
          end
        end
        S_NEW:  state <= S_URD;
        S_DRD:  state <= S_DCHK;
        S_DCHK: begin
          if (key_lt) begin
            cur_e <= {in_key, node_of(h_rd)};
            state <= S_DWR;
          end else begin
            state <= S_FIN;
          end
        end
        S_DWR:  state <= S_URD;
        // Sift-up: read parent, compare, swap.
        S_URD:  state <= (cur == '0) ? S_FIN : S_UCMP;
        S_UCMP: state <= key_lt ? S_USW : S_FIN;
        S_USW: begin
          cur <= par; state <= S_URD;
        end
        // Pop: clear the root's table entry and move the last entry up.
        S_PCLR: begin
          count <= last;
          state <= (count == CW'(1)) ? S_FIN : S_LGET;
        end
        S_LGET: begin
          cur <= '0; cur_e <= h_rd; state <= S_DN;
        end
        // Sift-down: read both children, pick the smaller, swap.
        S_DN:   state <= l_ok ? S_DR : S_FIN;
        S_DR: begin
          lft_e <= h_rd; l_lt <= key_lt; state <= S_DCMP;
        end
        S_DCMP: begin
          if (r_lt) begin
            oth <= rslot[SW-1:0]; state <= S_DSW;
          end else if (l_lt) begin
            oth <= lslot[SW-1:0]; state <= S_DSW;
          end else begin
            state <= S_FIN;
          end
        end
        S_DSW: begin
          cur <= oth; state <= S_DN;
        end
        S_FIN:  state <= S_FGET;
        S_FGET: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {6'd0, count_ext[8:0], empty,
                          empty ? 8'd0 : root_node_ext[7:0],
                          empty ? 32'd0 : root_key_ext[31:0]};
        m_axis_tuser  <= drop;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end
endmodule

// ----- tb/imh_heap_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_heap_checker: result checker for the indexed min-heap
// Watches both stream channels, keeps its own indexed heap updated by every
// accepted operation, queues the expected heap summary and compares each
// result transfer with the oldest queued summary, field by field.
// ----------------------------------------------------------------------------
module imh_heap_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // distance[31:0], node[39:32]
  input  logic        s_axis_tuser,   // op
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,   // top_distance, top_node, heap_empty, entry_count
  input  logic        m_axis_tuser,   // dropped
  output int          fail_count,
  output int          pending,
  output int          result_count,
  output int          max_entries,
  output int          drop_count
);
  localparam int SLOTS = imh_pkg::CAPACITY_DEF;
  localparam int NODES = imh_pkg::NODE_COUNT_DEF;

  typedef struct packed {
    logic [31:0] top_distance;
    logic [7:0]  top_node;
    logic        heap_empty;
    logic [8:0]  entry_count;
    logic        dropped;
  } heap_summary_t;

  logic [31:0] slot_key [SLOTS];
  logic [7:0]  slot_node [SLOTS];
  int          node_slot [NODES];
  bit          node_held [NODES];
  int          held;
  heap_summary_t summary_q[$];

  // Swap two heap slots and fix their position entries.
  function automatic void swap_slots(input int a, input int b);
    logic [31:0] k;
    logic [7:0]  n;
    k = slot_key[a]; n = slot_node[a];
    slot_key[a] = slot_key[b]; slot_node[a] = slot_node[b];
    slot_key[b] = k; slot_node[b] = n;
    node_slot[slot_node[a]] = a;
    node_slot[slot_node[b]] = b;
  endfunction

  function automatic void sift_up(input int s);
    int p;
    while (s > 0) begin
      p = (s - 1) / 2;
      if (!(slot_key[p] > slot_key[s])) break;
      swap_slots(s, p);
      s = p;
    end
  endfunction

  function automatic void sift_down(input int s);
    int best;
    forever begin
      best = s;
      if (2 * s + 1 < held && slot_key[2 * s + 1] < slot_key[best]) best = 2 * s + 1;
      if (2 * s + 2 < held && slot_key[2 * s + 2] < slot_key[best]) best = 2 * s + 2;
      if (best == s) break;
      swap_slots(s, best);
      s = best;
    end
  endfunction

  // Apply one operation and return the heap summary afterwards.
  function automatic heap_summary_t apply_op(input logic op, input logic [31:0] key,
                                             input logic [7:0] node);
    heap_summary_t r;
    int s;
    r = '0;
    if (op == imh_pkg::OP_PUSH) begin
      if (node_held[node]) begin
        s = node_slot[node];
        if (key < slot_key[s]) begin
          slot_key[s] = key;
          sift_up(s);
        end
      end else if (held >= SLOTS) begin
        r.dropped = 1'b1;
      end else begin
        slot_key[held] = key;
        slot_node[held] = node;
        node_held[node] = 1'b1;
        node_slot[node] = held;
        held++;
        sift_up(held - 1);
      end
    end else if (held > 0) begin
      node_held[slot_node[0]] = 1'b0;
      held--;
      if (held > 0) begin
        slot_key[0] = slot_key[held];
        slot_node[0] = slot_node[held];
        node_slot[slot_node[0]] = 0;
        sift_down(0);
      end
    end
    if (held > 0) begin
      r.top_distance = slot_key[0];
      r.top_node = slot_node[0];
    end else begin
      r.heap_empty = 1'b1;
    end
    r.entry_count = held[8:0];
    return r;
  endfunction

  // Predict on input transfers, compare on output transfers.
  always @(posedge clk) begin
    heap_summary_t exp_r, got;
    if (rst) begin
      held = 0;
      fail_count <= 0;
      result_count <= 0;
      max_entries <= 0;
      drop_count <= 0;
      pending <= 0;
      for (int i = 0; i < NODES; i++) node_held[i] = 1'b0;
      summary_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        exp_r = apply_op(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[39:32]);
        summary_q = {summary_q, exp_r};
        if (held > max_entries) max_entries <= held;
        if (exp_r.dropped) drop_count <= drop_count + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[39:32], m_axis_tdata[40],
               m_axis_tdata[49:41], m_axis_tuser};
        result_count <= result_count + 1;
        if (summary_q.size() == 0) begin
          $error("result transfer with no expected result waiting");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = summary_q.pop_front();
          if (got != exp_r) fail_count <= fail_count + 1;
          if (got.top_distance != exp_r.top_distance)
            $error("top_distance expected %0d actual %0d", exp_r.top_distance,
                   got.top_distance);
          if (got.top_node != exp_r.top_node)
            $error("top_node expected %0d actual %0d", exp_r.top_node, got.top_node);
          if (got.heap_empty != exp_r.heap_empty)
            $error("heap_empty expected %0d actual %0d", exp_r.heap_empty,
                   got.heap_empty);
          if (got.entry_count != exp_r.entry_count)
            $error("entry_count expected %0d actual %0d", exp_r.entry_count,
                   got.entry_count);
          if (got.dropped != exp_r.dropped)
            $error("dropped expected %0d actual %0d", exp_r.dropped, got.dropped);
        end
      end
      pending <= summary_q.size();
    end
  end
endmodule

// ----- tb/indexed_min_heap_decrease_key_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_top_test: stimulus for the indexed min-heap
// Drives directed and random push, decrease-key and pop operations with
// bursty input and stalling output; fills the heap to capacity and keeps
// pushing while full, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key_top_test;
  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // distance[31:0], node[39:32]
  logic        s_axis_tuser = 1'b0; // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // top_distance, top_node, heap_empty, entry_count
  logic        m_axis_tuser;        // dropped
  int          fail_count, pending, result_count, max_entries, drop_count;
  int          cycles = 0;
  bit          hold_off = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  indexed_min_heap_decrease_key_top dut (.*);

  imh_heap_checker heap_check (.*);

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stalls on its own pattern, with a long hold-off on request.
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off) m_axis_tready <= 1'b0;
      else if (phase % 600 < 150) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // One operation, held until accepted; valid stays up for the next in a burst.
  task automatic send_op(input logic op, input logic [31:0] key, input logic [7:0] node);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {node, key};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Occasionally end the burst with a random gap.
  task automatic random_gap();
    if ($urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [7:0] nd;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pop, extremes, ties, decrease-key, ignored raise.
    send_op(imh_pkg::OP_POP, 32'hFFFF_FFFF, 8'hFF);
    send_op(imh_pkg::OP_PUSH, 32'hFFFF_FFFF, 8'd0);
    send_op(imh_pkg::OP_PUSH, 32'hFFFF_FFFF, 8'hFF);
    send_op(imh_pkg::OP_PUSH, 32'd0, 8'd7);
    send_op(imh_pkg::OP_PUSH, 32'd0, 8'd8);
    send_op(imh_pkg::OP_PUSH, 32'd5, 8'd9);
    send_op(imh_pkg::OP_PUSH, 32'd5, 8'd10);
    send_op(imh_pkg::OP_PUSH, 32'd6, 8'd9);
    send_op(imh_pkg::OP_PUSH, 32'd5, 8'd9);
    send_op(imh_pkg::OP_PUSH, 32'd0, 8'hFF);
    send_op(imh_pkg::OP_PUSH, 32'd1, 8'd0);
    repeat (8) send_op(imh_pkg::OP_POP, $urandom(), 8'($urandom()));
    wait_drained();
    repeat (20) @(posedge clk);

    // Fill to capacity while the receiver holds off, then push while full.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < imh_pkg::CAPACITY_DEF; i++) begin
        send_op(imh_pkg::OP_PUSH, rand_key(), i[7:0]);
        random_gap();
      end
    join
    send_op(imh_pkg::OP_PUSH, 32'd0, 8'd3);
    repeat (3) send_op(imh_pkg::OP_PUSH, rand_key(), 8'($urandom()));
    wait_drained();
    repeat (20) @(posedge clk);

    // Random: mostly pushes with a small node range to hit decrease-key.
    for (int i = 0; i < 220; i++) begin
      if ($urandom_range(0, 2) == 0) nd = 8'($urandom());
      else nd = 8'($urandom_range(0, 31));
      if ($urandom_range(0, 9) < 4) send_op(imh_pkg::OP_POP, $urandom(), 8'($urandom()));
      else send_op(imh_pkg::OP_PUSH, rand_key(), nd);
      random_gap();
      if (i == 110) wait_drained();
    end
    wait_drained();
    repeat (100) @(posedge clk);

    $display("Ran %0d results; heap peaked at %0d entries with %0d full drops.",
             result_count, max_entries, drop_count);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
